// ----- rtl/bfsa_pkg.sv -----
`timescale 1ns / 1ps
package bfsa_pkg;

	// Configuration register indexes.
	localparam logic [2:0] CFG_SPT  = 3'd0;
	localparam logic [2:0] CFG_SPC  = 3'd1;
	localparam logic [2:0] CFG_SPB  = 3'd2;
	localparam logic [2:0] CFG_TOFS = 3'd3;
	localparam logic [2:0] CFG_SSZ  = 3'd4;
	localparam logic [2:0] CFG_VOL  = 3'd5;
	localparam logic [2:0] CFG_MODE = 3'd6;

	// Reset values of the registers.
	localparam logic [5:0]  RST_SPT  = 6'd26;
	localparam logic [6:0]  RST_SPC  = 7'd26;
	localparam logic [3:0]  RST_SPB  = 4'd4;
	localparam logic [2:0]  RST_TOFS = 3'd2;
	localparam logic [1:0]  RST_SSZ  = 2'd0;
	localparam logic [11:0] RST_VOL  = 12'd1950;
	localparam logic [3:0]  RST_MODE = 4'd0;

	localparam int MAX_BLOCK_DEF = 3000;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// Mode register bits.
	localparam int MODE_DSIDE = 0;
	localparam int MODE_ALT   = 1;
	localparam int MODE_ONE   = 2;
	localparam int MODE_WP    = 3;

	localparam logic [1:0] SSZ_1K = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_WPROT = 2'd2;

	localparam logic [9:0]  HALF_K  = 10'd512;
	localparam logic [10:0] BASE_SZ = 11'd128;
	localparam logic [7:0]  SIDE_BIT = 8'h80;

	// Classified item between the front and the back.
	typedef struct packed {
		logic [15:0] sec;
		logic [10:0] len;
		logic        odd;
		logic        part;
		logic [1:0]  status;
		logic [2:0]  drive;
	} mid_t;

	// Finished result.
	typedef struct packed {
		logic [7:0]  track;
		logic [7:0]  sector_code;
		logic [2:0]  drive;
		logic [9:0]  byte_offset;
		logic [10:0] transfer_length;
		logic        partial;
		logic [1:0]  status;
	} res_t;

endpackage

// ----- rtl/bfsa_fifo.sv -----
`timescale 1ns / 1ps
module bfsa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("fifo count past depth");
	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> !empty) else $error("push left fifo empty");
	a_pop_drain: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> !full) else $error("pop left fifo full");

endmodule

// ----- rtl/bfsa_front.sv -----
`timescale 1ns / 1ps
module bfsa_front #(
	parameter int MAX_BLOCK = bfsa_pkg::MAX_BLOCK_DEF
) (
	input  logic [11:0]       block_number,
	input  logic [15:0]       byte_count,
	input  logic              is_write,
	input  logic [2:0]        drive,
	input  logic [3:0]        spb,
	input  logic [1:0]        ssz,
	input  logic [11:0]       vol,
	input  logic [3:0]        mode,
	output bfsa_pkg::mid_t    item
);
	import bfsa_pkg::*;

	logic [10:0] bps;
	logic [10:0] len;
	logic [15:0] sec;
	logic        odd;
	logic [1:0]  status;

	always_comb begin
		bps = BASE_SZ << ssz;
		len = ({5'd0, bps} > byte_count) ? byte_count[10:0] : bps;
		odd = 1'b0;
		if (ssz == SSZ_1K) begin
			sec = {5'd0, block_number[11:1]};
			odd = block_number[0];
			if (odd && len > {1'b0, HALF_K}) len = {1'b0, HALF_K};
		end else begin
			sec = 16'(block_number * spb);
		end

		if (block_number > 12'(MAX_BLOCK)) status = ST_RANGE;
		else if (is_write && mode[MODE_WP]) status = ST_WPROT;
		else if (sec >= {4'd0, vol}) status = ST_RANGE;
		else status = ST_OK;

		item.sec    = sec;
		item.drive  = drive;
		item.status = status;
		if (status == ST_OK) begin
			item.len  = len;
			item.odd  = odd;
			item.part = odd || ({5'd0, bps} > byte_count);
		end else begin
			item.len  = '0;
			item.odd  = 1'b0;
			item.part = 1'b0;
		end
	end

endmodule

// ----- rtl/bfsa_back.sv -----
`timescale 1ns / 1ps
module bfsa_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  bfsa_pkg::mid_t in_item,
	input  logic [5:0]     spt,
	input  logic [6:0]     spc,
	input  logic [2:0]     tofs,
	input  logic [3:0]     mode,
	output logic           out_valid,
	output bfsa_pkg::res_t out_res
);
	import bfsa_pkg::*;

	localparam int NSTEP = 16;

	typedef struct packed {
		logic [15:0] num;
		logic [6:0]  rem;
	} lane_t;

	typedef struct packed {
		mid_t  m;
		lane_t cyl;
		lane_t trk;
	} div_t;

	function automatic lane_t div_step(lane_t a, logic [6:0] d);
		logic [7:0] t;
		lane_t r;
		t = {a.rem, a.num[15]};
		if (t >= {1'b0, d}) begin
			r.rem = 7'(t - {1'b0, d});
			r.num = {a.num[14:0], 1'b1};
		end else begin
			r.rem = t[6:0];
			r.num = {a.num[14:0], 1'b0};
		end
		return r;
	endfunction

	div_t div_q [NSTEP+1];
	logic [NSTEP:0] vld_q;

	always_ff @(posedge clk) begin
		if (en) begin
			div_q[0].m <= in_item;
			div_q[0].cyl <= '{num: in_item.sec, rem: '0};
			div_q[0].trk <= '{num: in_item.sec, rem: '0};
			for (int k = 0; k < NSTEP; k++) begin
				div_q[k+1].m <= div_q[k].m;
				div_q[k+1].cyl <= div_step(div_q[k].cyl, spc);
				div_q[k+1].trk <= div_step(div_q[k].trk, {1'b0, spt});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTEP-1:0], in_valid};
		end
	end

	div_t   fin;
	logic [7:0] sc;
	logic [7:0] sa;

	always_comb begin
		fin = div_q[NSTEP];
		sc = {1'b0, fin.trk.rem};
		if (mode[MODE_ALT]) begin
			sa = {fin.trk.rem, 1'b0};
			if (!spt[0] && sa >= {2'd0, spt}) sa = sa + 8'd1;
			if (sa >= {2'd0, spt}) sa = sa - {2'd0, spt};
			sc = sa;
		end else begin
			sa = '0;
		end
		if (mode[MODE_ONE]) sc = sc + 8'd1;
		if (mode[MODE_DSIDE] && fin.cyl.rem >= {1'b0, spt}) sc = sc | SIDE_BIT;

		out_res.drive = fin.m.drive;
		out_res.status = fin.m.status;
		out_res.transfer_length = fin.m.len;
		out_res.partial = fin.m.part;
		out_res.byte_offset = fin.m.odd ? HALF_K : '0;
		if (fin.m.status == ST_OK) begin
			out_res.track = fin.cyl.num[7:0] + {5'd0, tofs};
			out_res.sector_code = sc;
		end else begin
			out_res.track = '0;
			out_res.sector_code = '0;
		end
	end

	assign out_valid = vld_q[NSTEP];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_q == $past(vld_q)) else $error("pipeline moved while held");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_q[0] |=> vld_q[1]) else $error("item lost in divider");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.status != ST_OK |-> out_res.track == '0 &&
		out_res.sector_code == '0) else $error("error result carries address");

endmodule

// ----- rtl/block_to_floppy_sector_address.sv -----
`timescale 1ns / 1ps
// Floppy block-to-sector translator. Each item pushed in is a file system block request; one
// result item comes out per request, in order, giving the track, the sector on the track (bit 7
// marks the second side), the byte offset and length of the first transfer, and a status. The
// front classifies a request in the cycle it is pushed (sector number, length, range and write
// protect checks) into a four-entry queue. The back runs two 16-stage restoring dividers side by
// side, one bit per stage, for the sector over sectors per cylinder and sectors per track, and
// then applies interleave, origin and side. One item enters the divider per cycle while the
// output queue has room; a request passes through the input queue, the divider's load register
// and its 16 step stages into the output queue. The divider pipeline advances only while the
// two-entry output queue has room, so when results are held back the pipeline stops. While the
// output queue is full the pipeline waits even if a result is popped, and moves once the pop
// has freed an entry. Geometry registers may be written only while no request is in flight.
module block_to_floppy_sector_address #(
	parameter int MAX_BLOCK = bfsa_pkg::MAX_BLOCK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [11:0] block_number,
	input  logic [15:0] byte_count,
	input  logic        is_write,
	input  logic [2:0]  drive,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  track,
	output logic [7:0]  sector_code,
	output logic [2:0]  drive_out,
	output logic [9:0]  byte_offset,
	output logic [10:0] transfer_length,
	output logic        partial,
	output logic [1:0]  status
);
	import bfsa_pkg::*;

	// Geometry registers.
	logic [5:0]  spt_q;
	logic [6:0]  spc_q;
	logic [3:0]  spb_q;
	logic [2:0]  tofs_q;
	logic [1:0]  ssz_q;
	logic [11:0] vol_q;
	logic [3:0]  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q  <= RST_SPT;
			spc_q  <= RST_SPC;
			spb_q  <= RST_SPB;
			tofs_q <= RST_TOFS;
			ssz_q  <= RST_SSZ;
			vol_q  <= RST_VOL;
			mode_q <= RST_MODE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SPT:  spt_q  <= cfg_data[5:0];
				CFG_SPC:  spc_q  <= cfg_data[6:0];
				CFG_SPB:  spb_q  <= cfg_data[3:0];
				CFG_TOFS: tofs_q <= cfg_data[2:0];
				CFG_SSZ:  ssz_q  <= cfg_data[1:0];
				CFG_VOL:  vol_q  <= cfg_data;
				CFG_MODE: mode_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// A zero divisor is treated as one.
	logic [5:0] spt_eff;
	logic [6:0] spc_eff;
	assign spt_eff = (spt_q == '0) ? 6'd1 : spt_q;
	assign spc_eff = (spc_q == '0) ? 7'd1 : spc_q;

	mid_t front_item;
	mid_t mid_item;
	logic mid_empty;
	logic en;
	logic out_full;
	logic back_valid;
	res_t back_res;
	res_t out_res;

	bfsa_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
		.block_number(block_number),
		.byte_count(byte_count),
		.is_write(is_write),
		.drive(drive),
		.spb(spb_q),
		.ssz(ssz_q),
		.vol(vol_q),
		.mode(mode_q),
		.item(front_item)
	);

	bfsa_fifo #(.WIDTH($bits(mid_t)), .DEPTH(MID_DEPTH)) u_mid (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(front_item),
		.full(full),
		.pop(en),
		.rdata(mid_item),
		.empty(mid_empty)
	);

	// The divider pipeline moves whenever the output queue has room for its last stage.
	assign en = !out_full;

	bfsa_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(!mid_empty),
		.in_item(mid_item),
		.spt(spt_eff),
		.spc(spc_eff),
		.tofs(tofs_q),
		.mode(mode_q),
		.out_valid(back_valid),
		.out_res(back_res)
	);

	bfsa_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(en && back_valid),
		.wdata(back_res),
		.full(out_full),
		.pop(pop),
		.rdata(out_res),
		.empty(empty)
	);

	assign track           = out_res.track;
	assign sector_code     = out_res.sector_code;
	assign drive_out       = out_res.drive;
	assign byte_offset     = out_res.byte_offset;
	assign transfer_length = out_res.transfer_length;
	assign partial         = out_res.partial;
	assign status          = out_res.status;

endmodule
